@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge, off while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never hold on a rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/lsvd_pkg.sv @@
// Types and constants of the LIFO stack with value delete.
package lsvd_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [63:0] item_value;
    } t_item;

    typedef struct packed {
        logic [63:0] result_value;
        t_status     status;
        logic [4:0]  entry_count;
    } t_result;

    // read address select of the entry store
    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_PTR  = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    // scan pointer update
    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_TOP  = 2'd1,
        PTR_DEC  = 2'd2,
        PTR_INC  = 2'd3
    } t_ptr_op;

    typedef struct packed {
        logic    load;      // latch the request value
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    push_wr;   // write value at count, count + 1
        logic    shift_wr;  // write read data at pointer
        t_ptr_op ptr_op;
        logic    cnt_dec;
        logic    emit;      // present a result
        logic    emit_data; // result carries read data
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;       // read data equals request value
        logic ptr_zero;
        logic ptr_at_top;  // pointer on the top entry
        logic shift_last;  // pointer + 1 is the top entry
    } t_dp_stat;

endpackage

@@ rtl/lsvd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsvd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lsvd_dp.sv @@
// Datapath: entry store, fill count, scan pointer and result register.
`include "assert_macros.svh"
module lsvd_dp import lsvd_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_item_value,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    output t_result     o_result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    logic [CW-1:0] r_count, n_count, count_m1;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [63:0]   r_val;
    logic [63:0]   rdata;
    logic [AW-1:0] raddr, waddr;
    logic [63:0]   wdata;
    logic [XW-1:0] count_x;
    logic          r_valid;
    t_result       r_result, n_result;

    assign count_m1 = r_count - CW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_TOP:  raddr = count_m1[AW-1:0];
            RD_PTR:  raddr = r_ptr;
            RD_NEXT: raddr = r_ptr + AW'(1);
            default: raddr = r_ptr;
        endcase
    end

    assign waddr = i_cmd.push_wr ? r_count[AW-1:0] : r_ptr;
    assign wdata = i_cmd.push_wr ? r_val : rdata;

    lsvd_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_wr | i_cmd.shift_wr),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = count_m1;
        end
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_HOLD: n_ptr = r_ptr;
            PTR_TOP:  n_ptr = count_m1[AW-1:0];
            PTR_DEC:  n_ptr = r_ptr - AW'(1);
            PTR_INC:  n_ptr = r_ptr + AW'(1);
            default:  n_ptr = r_ptr;
        endcase
    end

    // entry count is reported modulo 32
    assign count_x = XW'(n_count);

    always_comb begin
        n_result.result_value = i_cmd.emit_data ? rdata : 64'd0;
        n_result.status       = i_cmd.status;
        n_result.entry_count  = count_x[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_val <= i_item_value;
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_stat.full       = (r_count == CW'(STACK_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.match      = (rdata == r_val);
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.ptr_at_top = (CW'(r_ptr) == count_m1);
    assign o_stat.shift_last = ((CW'(r_ptr) + CW'(1)) == count_m1);

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(STACK_DEPTH))
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_cmd.push_wr && o_stat.full)
    `ASSERT_NEVER(a_dec_empty, i_clk, i_rst_n, i_cmd.cnt_dec && o_stat.empty)

endmodule

@@ rtl/lsvd_ctrl.sv @@
// Controller: request sequencing for push, pop, peek and delete.
`include "assert_macros.svh"
module lsvd_ctrl import lsvd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_action  i_action,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    t_state  r_state, n_state;
    t_action r_act;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                // keep the top entry read so pop/peek have it next cycle
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TOP;
                cmd.load   = i_start;
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_act)
                    ACT_PUSH: begin
                        cmd.emit = 1'b1;
                        if (i_stat.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.push_wr = 1'b1;
                            cmd.status  = ST_DONE;
                        end
                    end
                    ACT_POP, ACT_PEEK: begin
                        cmd.emit = 1'b1;
                        if (i_stat.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.emit_data = 1'b1;
                            cmd.cnt_dec   = (r_act == ACT_POP);
                            cmd.status    = ST_DONE;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.ptr_op = PTR_TOP;
                            n_state    = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PTR;
                n_state    = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    if (i_stat.ptr_at_top) begin
                        cmd.cnt_dec = 1'b1;
                        cmd.emit    = 1'b1;
                        cmd.status  = ST_DONE;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (i_stat.ptr_zero) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    cmd.ptr_op = PTR_DEC;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                n_state    = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move entry above the pointer down one slot
                cmd.shift_wr = 1'b1;
                cmd.ptr_op   = PTR_INC;
                if (i_stat.shift_last) begin
                    cmd.cnt_dec = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.status  = ST_DONE;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_PUSH;
        end else begin
            r_state <= n_state;
            if (cmd.load) begin
                r_act <= i_action;
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    `ASSERT_PROP(a_emit_then_idle, i_clk, i_rst_n, cmd.emit |=> !o_busy)
    `ASSERT_NEVER(a_write_conflict, i_clk, i_rst_n, cmd.push_wr && cmd.shift_wr)

endmodule

@@ rtl/lifo_stack_with_value_delete_unit.sv @@
// Top level of the LIFO stack with value delete.
//
//  channel   direction  handshake                     payload
//  request   in         i_start, transfer when !o_busy i_item   (t_item)
//  result    out        o_valid, one-cycle strobe      o_result (t_result)
//
// Sequence: push, pop and peek emit their result from the execute state. Delete
// passes it, then reads and compares entries from the top down, then reads and
// writes each entry moved down to close the gap; each step waits on the RAM read.
// Reset: synchronous, active low; clears fill count, controller and strobe.
// Entry RAM is not cleared; only slots below the fill count feed a result.
// Result side cannot stall: o_valid lasts one cycle, a request may transfer then.
module lifo_stack_with_value_delete_unit import lsvd_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: decodes the request, walks entries on delete
    lsvd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_item.action),
        .i_stat   (dp_stat),
        .o_busy   (o_busy),
        .o_cmd    (dp_cmd)
    );

    // storage, count, scan pointer and result register
    lsvd_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_value (i_item.item_value),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

endmodule

@@ verif/lsvd_stack_checker.sv @@
// Checker for the LIFO stack with value delete: predicts each result and compares.
`timescale 1ns / 1ps

module lsvd_stack_checker import lsvd_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_valid,
    input  t_result i_result,
    output int      o_errors,
    output int      o_outstanding
);

    logic [63:0] slots [STACK_DEPTH];
    int          held;
    t_result     awaited_results [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        held          = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
        o_errors++;
    endtask

    // Applies one request to the shadow stack and returns what the block must answer.
    function automatic t_result stack_outcome(input t_item req);
        t_result res;
        int      hit;
        int      i;
        res.result_value = '0;
        res.status       = ST_DONE;
        hit              = -1;
        case (req.action)
            ACT_PUSH: begin
                if (held >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slots[held] = req.item_value;
                    held++;
                end
            end
            ACT_POP: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held--;
                    res.result_value = slots[held];
                end
            end
            ACT_PEEK: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.result_value = slots[held - 1];
                end
            end
            default: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // uppermost match wins
                    for (i = held - 1; i >= 0 && hit < 0; i--) begin
                        if (slots[i] == req.item_value) hit = i;
                    end
                    if (hit < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        for (i = hit; i + 1 < held; i++) slots[i] = slots[i + 1];
                        held--;
                    end
                end
            end
        endcase
        res.entry_count = 5'(held);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            held = 0;
        end else begin
            // result first: a request taken at this edge cannot answer at it
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", '0,
                                    i_result.result_value);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.result_value !== want.result_value)
                        report_mismatch("result_value", want.result_value,
                                        i_result.result_value);
                    if (i_result.status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(i_result.status));
                    if (i_result.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(want.entry_count),
                                        64'(i_result.entry_count));
                end
            end
            if (i_start && !i_busy) awaited_results.push_back(stack_outcome(i_item));
        end
        o_outstanding = awaited_results.size();
    end

endmodule

@@ verif/tb_lifo_stack_with_value_delete_unit.sv @@
// Testbench top of the LIFO stack with value delete: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_lifo_stack_with_value_delete_unit;
    import lsvd_pkg::*;

    // Worst request is a delete on a full stack, which scans and shifts entries.
    // Roughly 530 requests, each no longer than that, stay far below this limit.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 500;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_item   i_item;
    logic    o_busy;
    logic    o_valid;
    t_result o_result;

    int          errors;
    int          outstanding;
    int          cycle_count;
    logic [63:0] value_pool [8];

    lifo_stack_with_value_delete_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    lsvd_stack_checker stack_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_item        (i_item),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Drive one request at the falling edge and hold it until the block takes
    // the transfer. start stays high on return so back-to-back requests never
    // see a low pulse in between.
    task automatic issue(input t_action act, input logic [63:0] value);
        @(negedge i_clk);
        i_start           <= 1'b1;
        i_item.action     <= act;
        i_item.item_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Sender idles; the payload carries junk that must be ignored.
    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start           <= 1'b0;
            i_item.action     <= t_action'($urandom_range(3));
            i_item.item_value <= {$urandom, $urandom};
        end
    endtask

    task automatic drain();
        pause(1);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Half the values come from a small pool so deletes hit and duplicates pile up.
    function automatic logic [63:0] pick_value();
        if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_action act;
        int      n;
        int      roll;
        bit      filling;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        filling = 1'b1;
        for (n = 0; n < 8; n++) value_pool[n] = {$urandom, $urandom};
        value_pool[0] = '0;
        value_pool[1] = '1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-stack corner cases.
        issue(ACT_POP,    64'h0);
        issue(ACT_PEEK,   64'h0);
        issue(ACT_DELETE, 64'h0);
        // Extremes plus a duplicated value.
        issue(ACT_PUSH,   64'h0);
        issue(ACT_PUSH,   '1);
        issue(ACT_PUSH,   64'hA5A5_5A5A_A5A5_5A5A);
        issue(ACT_PUSH,   64'hA5A5_5A5A_A5A5_5A5A);
        issue(ACT_PUSH,   64'h5A5A_A5A5_5A5A_A5A5);
        // Delete removes only the upper copy, then the top entry goes,
        // then a miss leaves the stack alone.
        issue(ACT_DELETE, 64'hA5A5_5A5A_A5A5_5A5A);
        issue(ACT_DELETE, 64'h5A5A_A5A5_5A5A_A5A5);
        issue(ACT_DELETE, 64'h0123_4567_89AB_CDEF);
        issue(ACT_PEEK,   64'h0);
        issue(ACT_POP,    64'h0);
        // Fill to the brim, overflow once, then delete the bottom entry,
        // which makes every other entry move down.
        repeat (14) issue(ACT_PUSH, {$urandom, $urandom});
        issue(ACT_PUSH,   64'hFFFF_0000_FFFF_0000);
        issue(ACT_DELETE, 64'h0);
        drain();

        // Random phase: alternate fill-heavy and drain-heavy runs so the stack
        // swings between empty and full. Only the drain at item 250 idles in the middle stretch.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ((n < 150 || n >= 300) && $urandom_range(99) < 11)
                pause(1 + $urandom_range(3));
            if (n == 250) drain();
            if ($urandom_range(24) == 0) filling = !filling;
            roll = $urandom_range(99);
            if (filling)
                act = (roll < 55) ? ACT_PUSH : (roll < 70) ? ACT_POP :
                      (roll < 80) ? ACT_PEEK : ACT_DELETE;
            else
                act = (roll < 15) ? ACT_PUSH : (roll < 55) ? ACT_POP :
                      (roll < 65) ? ACT_PEEK : ACT_DELETE;
            issue(act, pick_value());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
